// ----- rtl/lmfd_pkg.sv -----
// Package: shared types and constants for the LED mode frame driver.
`timescale 1ns / 1ps
package lmfd_pkg;

  localparam int unsigned FRAME_W  = 24;
  localparam int unsigned TICK_W   = 9;
  localparam int unsigned SLOW_BIT = 8;
  localparam int unsigned FAST_BIT = 6;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_PULSE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;
  localparam logic [1:0] MODE_FAST = 2'd3;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic REG_ACTIVE_HIGH = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  led_index;
    logic [1:0]  mode_value;
    logic [15:0] pulse_length;
  } lmfd_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] frame_bits;
    logic [1:0]  mode_readback;
  } lmfd_out_t;

  typedef struct packed {
    logic        shift_en;
    logic        set_mode;
    logic        set_pulse;
    logic [4:0]  led_index;
    logic [1:0]  mode_value;
    logic [15:0] pulse_length;
    logic        slow_phase;
    logic        fast_phase;
  } lmfd_ctrl_t;

endpackage

// ----- rtl/lmfd_cfg.sv -----
// APB configuration register holding the output polarity.
`timescale 1ns / 1ps
module lmfd_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        active_high
);
  import lmfd_pkg::*;

  logic active_high_r;
  logic active_high_nxt;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_HIGH);

  always_comb begin
    active_high_nxt = active_high_r;
    if (wr_hit) begin
      active_high_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= 1'b1;
    end else begin
      active_high_r <= active_high_nxt;
    end
  end

  assign prdata      = (paddr[2] == REG_ACTIVE_HIGH) ? {31'd0, active_high_r} : 32'd0;
  assign active_high = active_high_r;

endmodule

// ----- rtl/lmfd_scan.sv -----
// LED state store, rotated one LED per cycle during a tick scan.
`timescale 1ns / 1ps
module lmfd_scan #(
  parameter int unsigned LED_COUNT = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lmfd_pkg::lmfd_ctrl_t ctrl,
  output logic [1:0]           rd_mode,
  output logic [23:0]          word
);
  import lmfd_pkg::*;

  localparam int unsigned IDXW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [1:0]         mode_r    [LED_COUNT];
  logic [1:0]         mode_nxt  [LED_COUNT];
  logic [15:0]        pulse_r   [LED_COUNT];
  logic [15:0]        pulse_nxt [LED_COUNT];
  logic [FRAME_W-1:0] sh_r;
  logic [FRAME_W-1:0] sh_nxt;
  logic [IDXW-1:0]    idx;
  logic               lit;
  logic [15:0]        head_pulse;

  assign idx = ctrl.led_index[IDXW-1:0];

  // head LED: lamp state for this tick and its decremented pulse
  always_comb begin
    case (mode_r[0])
      MODE_ON:   lit = 1'b1;
      MODE_SLOW: lit = ctrl.slow_phase;
      MODE_FAST: lit = ctrl.fast_phase;
      default:   lit = 1'b0;
    endcase
    if (pulse_r[0] != 16'd0) begin
      lit = 1'b1;
    end
    head_pulse = (pulse_r[0] != 16'd0) ? (pulse_r[0] - 16'd1) : 16'd0;
  end

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      mode_nxt[i]  = mode_r[i];
      pulse_nxt[i] = pulse_r[i];
    end
    sh_nxt = sh_r;
    if (ctrl.shift_en) begin
      for (int i = 0; i < LED_COUNT - 1; i++) begin
        mode_nxt[i]  = mode_r[i+1];
        pulse_nxt[i] = pulse_r[i+1];
      end
      mode_nxt[LED_COUNT-1]  = mode_r[0];
      pulse_nxt[LED_COUNT-1] = head_pulse;
      sh_nxt = {lit, sh_r[FRAME_W-1:1]};
    end else begin
      if (ctrl.set_mode) begin
        mode_nxt[idx] = ctrl.mode_value;
      end
      if (ctrl.set_pulse) begin
        pulse_nxt[idx] = ctrl.pulse_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        mode_r[i]  <= MODE_OFF;
        pulse_r[i] <= 16'd0;
      end
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        mode_r[i]  <= mode_nxt[i];
        pulse_r[i] <= pulse_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign rd_mode = mode_r[idx];
  assign word    = FRAME_W'(sh_r >> (FRAME_W - LED_COUNT));

endmodule

// ----- rtl/led_mode_frame_driver.sv -----
// Top level: command sequencer, frame change detection and result register.
//
// Usage. Commands enter on in_data when start is high and busy is low.
// Set mode and start pulse are absorbed in the accepting cycle and give no
// result; busy stays low. Read mode gives a readback transaction on the
// out_ ports in the cycle after acceptance. A tick walks the LED store one
// LED per cycle: busy stays high through this serial scan and the end state
// that follows it, so no new command is taken during a tick. In the end state
// the frame, when it differs from the previous one or is the first, is
// registered onto the out_ ports. Each result is shown for exactly one cycle
// with out_valid high; the receiver cannot stall and must take it then.
// Polarity is set through the APB port (register 0, active_high); the user
// must set it only while the block is idle, which the block does not enforce.
// Synchronous reset clears all modes and pulses, the tick count and the
// first-frame flag, and sets active_high.
`timescale 1ns / 1ps
module led_mode_frame_driver #(
  parameter int unsigned LED_COUNT = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lmfd_pkg::lmfd_in_t  in_data,
  output logic                out_valid,
  output lmfd_pkg::lmfd_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lmfd_pkg::*;

  localparam int unsigned CNTW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [FRAME_W-1:0] prev_r, prev_nxt;
  logic               sent_r, sent_nxt;
  logic               out_valid_r, out_valid_nxt;
  lmfd_out_t          out_r, out_nxt;
  logic               accept;
  logic               in_range;
  logic               active_high;
  logic [1:0]         rd_mode;
  logic [FRAME_W-1:0] word;
  lmfd_ctrl_t         ctrl;

  lmfd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .active_high (active_high)
  );

  lmfd_scan #(.LED_COUNT(LED_COUNT)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_mode (rd_mode),
    .word    (word)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(in_data.led_index) < LED_COUNT);

  always_comb begin
    ctrl.shift_en     = (state_r == ST_SCAN);
    ctrl.set_mode     = accept && (in_data.opcode == OP_SET) && in_range;
    ctrl.set_pulse    = accept && (in_data.opcode == OP_PULSE) && in_range;
    ctrl.led_index    = in_data.led_index;
    ctrl.mode_value   = in_data.mode_value;
    ctrl.pulse_length = in_data.pulse_length;
    ctrl.slow_phase   = tick_r[SLOW_BIT];
    ctrl.fast_phase   = tick_r[FAST_BIT];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    prev_nxt      = prev_r;
    sent_nxt      = sent_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_TICK) begin
            tick_nxt  = tick_r + 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else if (in_data.opcode == OP_READ) begin
            out_valid_nxt         = 1'b1;
            out_nxt.result_kind   = KIND_READ;
            out_nxt.frame_bits    = '0;
            out_nxt.mode_readback = in_range ? rd_mode : MODE_OFF;
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(LED_COUNT - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
        if (!sent_r || (word != prev_r)) begin
          prev_nxt              = word;
          sent_nxt              = 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_FRAME;
          out_nxt.frame_bits    = active_high ? word : ~word;
          out_nxt.mode_readback = MODE_OFF;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tick_r      <= '0;
      prev_r      <= '0;
      sent_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      prev_r      <= prev_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_read_frame_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_READ) |-> out_data.frame_bits == '0)
    else $error("readback transaction carries frame bits");

  a_frame_mode_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_FRAME) |-> out_data.mode_readback == MODE_OFF)
    else $error("frame transaction carries a readback mode");

  a_frame_after_fin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_FRAME) |-> $past(state_r) == ST_FIN)
    else $error("frame emitted outside the end of a scan");

  a_scan_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> 32'(cnt_r) < LED_COUNT)
    else $error("scan counter beyond LED count");

  a_fin_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (state_r == ST_IDLE) && sent_r)
    else $error("scan end did not return to idle with a frame recorded");

endmodule
